### rtl/bbf_pkg.sv
// bbf_pkg: shared types, constants and byte classification for the bracket balance filter
// no dependencies; used by bbf_front, bbf_back and bracket_balance_filter
package bbf_pkg;

  localparam logic [7:0] OPEN_BYTE = 8'h28;

  // short queue between the front and the back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPW = $clog2(QUEUE_DEPTH);
  localparam int QCW = $clog2(QUEUE_DEPTH + 1);

  // one classified beat as it travels through the queue
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       letter;
    logic       open_b;
  } item_t;

  // back status seen by the top level
  typedef struct packed {
    logic replay;
    logic q_pop;
  } status_t;

  function automatic logic is_letter(input logic [7:0] c);
    is_letter = (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
  endfunction

endpackage

### rtl/bbf_ram.sv
// bbf_ram: generic single-write, single-read memory with registered read data
// no dependencies
module bbf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/bbf_front.sv
// bbf_front: accepts input beats, classifies each byte and holds it in a short queue
// depends on bbf_pkg
module bbf_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [7:0]     in_char,
  input  logic           in_last,
  output logic           busy,
  output logic           q_valid,
  output bbf_pkg::item_t q_item,
  input  logic           q_pop
);

  bbf_pkg::item_t              q_mem [bbf_pkg::QUEUE_DEPTH];
  logic [bbf_pkg::QPW-1:0]     wptr;
  logic [bbf_pkg::QPW-1:0]     rptr;
  logic [bbf_pkg::QCW-1:0]     level;
  logic                        push;
  bbf_pkg::item_t              new_item;

  assign busy    = (level == bbf_pkg::QCW'(bbf_pkg::QUEUE_DEPTH));
  assign push    = start && !busy;
  assign q_valid = (level != '0);
  assign q_item  = q_mem[rptr];

  always_comb begin
    new_item.data   = in_char;
    new_item.last   = in_last;
    new_item.letter = bbf_pkg::is_letter(in_char);
    new_item.open_b = (in_char == bbf_pkg::OPEN_BYTE);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wptr] <= new_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      level <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (q_pop) begin
        rptr <= rptr + 1'b1;
      end
      if (push && !q_pop) begin
        level <= level + 1'b1;
      end else if (!push && q_pop) begin
        level <= level - 1'b1;
      end
    end
  end

endmodule

### rtl/bbf_back.sv
// bbf_back: stores bytes, matches brackets on a position stack, then replays the string
// depends on bbf_pkg and bbf_ram
module bbf_back #(
  parameter int MAX_LEN = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  bbf_pkg::item_t   q_item,
  output logic             q_pop,
  output bbf_pkg::status_t status,
  output logic             strobe,
  output logic [7:0]       out_char,
  output logic             out_last,
  output logic             out_empty,
  output logic             overflow
);

  localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int CW = $clog2(MAX_LEN + 1);

  localparam logic ST_LOAD   = 1'b0;
  localparam logic ST_REPLAY = 1'b1;

  logic               state;
  logic [CW-1:0]      count;
  logic [CW-1:0]      depth;
  logic               ovf_seen;
  logic [MAX_LEN-1:0] flags;
  logic [AW-1:0]      tos;
  logic               pop_d;

  // replay
  logic [CW-1:0] i;
  logic [CW-1:0] p;
  logic          a_ok;
  logic          b_ok;
  logic [7:0]    pend;
  logic          pend_valid;
  logic          ov_r;

  logic [7:0]    a_data;
  logic [7:0]    pat_char;
  logic [AW-1:0] stk_rdata;

  logic          room;
  logic          store_we;
  logic          do_push;
  logic          do_pop;
  logic [AW-1:0] tos_eff;
  logic [CW-1:0] depth_m1;
  logic [CW-1:0] depth_m2;

  logic          fin;
  logic          p_has;
  logic          flagp;
  logic          pat_ready;
  logic          keep;
  logic          consume;
  logic          i_adv;
  logic          p_adv;

  logic          emit_v;
  logic [7:0]    emit_char;
  logic          emit_last;
  logic          emit_empty;

  assign q_pop         = (state == ST_LOAD) && q_valid;
  assign status.replay = (state == ST_REPLAY);
  assign status.q_pop  = q_pop;

  // load side
  assign room     = (count < CW'(MAX_LEN));
  assign store_we = q_pop && room;
  assign depth_m1 = depth - CW'(1);
  assign depth_m2 = depth - CW'(2);
  assign tos_eff  = pop_d ? stk_rdata : tos;
  assign do_push  = store_we && q_item.open_b && (depth < CW'(MAX_LEN));
  assign do_pop   = store_we && !q_item.letter && !q_item.open_b && (depth != '0);

  bbf_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_store_a (
    .clk   (clk),
    .we    (store_we),
    .waddr (count[AW-1:0]),
    .wdata (q_item.data),
    .raddr (i[AW-1:0]),
    .rdata (a_data)
  );

  // second copy of the store for the pattern pointer
  bbf_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_store_b (
    .clk   (clk),
    .we    (store_we),
    .waddr (count[AW-1:0]),
    .wdata (q_item.data),
    .raddr (p[AW-1:0]),
    .rdata (pat_char)
  );

  // entries below the top of stack; the top lives in tos
  bbf_ram #(.WIDTH(AW), .DEPTH(MAX_LEN)) u_stack (
    .clk   (clk),
    .we    (do_push && (depth != '0)),
    .waddr (depth_m1[AW-1:0]),
    .wdata (tos_eff),
    .raddr (depth_m2[AW-1:0]),
    .rdata (stk_rdata)
  );

  // replay side
  assign fin       = (i >= count);
  assign p_has     = (p < count);
  assign flagp     = p_has && flags[p[AW-1:0]];
  assign pat_ready = b_ok && flagp;

  always_comb begin
    keep    = 1'b0;
    consume = 1'b0;
    i_adv   = 1'b0;
    if (state == ST_REPLAY && !fin && a_ok) begin
      if (bbf_pkg::is_letter(a_data)) begin
        keep  = 1'b1;
        i_adv = 1'b1;
      end else if (!p_has) begin
        i_adv = 1'b1;
      end else if (pat_ready) begin
        i_adv = 1'b1;
        if (pat_char == a_data) begin
          keep    = 1'b1;
          consume = 1'b1;
        end
      end
    end
    p_adv = (state == ST_REPLAY) && p_has && (!flagp || consume);
  end

  always_comb begin
    emit_v     = 1'b0;
    emit_char  = pend;
    emit_last  = 1'b0;
    emit_empty = 1'b0;
    if (state == ST_REPLAY) begin
      if (fin) begin
        emit_v    = 1'b1;
        emit_last = 1'b1;
        if (!pend_valid) begin
          emit_char  = '0;
          emit_empty = 1'b1;
        end
      end else if (keep && pend_valid) begin
        emit_v = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_LOAD;
      count      <= '0;
      depth      <= '0;
      ovf_seen   <= 1'b0;
      flags      <= '0;
      pop_d      <= 1'b0;
      i          <= '0;
      p          <= '0;
      a_ok       <= 1'b0;
      b_ok       <= 1'b0;
      pend_valid <= 1'b0;
      strobe     <= 1'b0;
    end else begin
      strobe <= emit_v;
      pop_d  <= do_pop;
      case (state)
        ST_LOAD: begin
          if (q_pop) begin
            if (room) begin
              count <= count + CW'(1);
            end else begin
              ovf_seen <= 1'b1;
            end
            if (do_push) begin
              depth <= depth + CW'(1);
            end else if (do_pop) begin
              depth <= depth_m1;
              // mark the popped open and this closer together
              flags <= flags | (MAX_LEN'(1) << tos_eff) | (MAX_LEN'(1) << count[AW-1:0]);
            end
            if (q_item.last) begin
              state      <= ST_REPLAY;
              i          <= '0;
              p          <= '0;
              a_ok       <= 1'b0;
              b_ok       <= 1'b0;
              pend_valid <= 1'b0;
            end
          end
        end
        ST_REPLAY: begin
          a_ok <= !i_adv;
          b_ok <= !p_adv;
          if (i_adv) begin
            i <= i + CW'(1);
          end
          if (p_adv) begin
            p <= p + CW'(1);
          end
          if (keep) begin
            pend_valid <= 1'b1;
          end
          if (fin) begin
            state    <= ST_LOAD;
            count    <= '0;
            depth    <= '0;
            ovf_seen <= 1'b0;
            flags    <= '0;
          end
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (!do_push) begin
      tos <= tos_eff;
    end else begin
      tos <= count[AW-1:0];
    end
    if (state == ST_LOAD && q_pop && q_item.last) begin
      ov_r <= ovf_seen || !room;
    end
    if (keep) begin
      pend <= a_data;
    end
    out_char  <= emit_char;
    out_last  <= emit_last;
    out_empty <= emit_empty;
    overflow  <= ov_r;
  end

endmodule

### rtl/bracket_balance_filter.sv
// bracket_balance_filter: top level, front classifier and queue feeding the bracket back end
// depends on bbf_pkg, bbf_front, bbf_back (and bbf_ram through bbf_back)
//
// usage
//   a string arrives one byte per beat on in_char, in_last marking its final byte;
//   a beat is taken at a rising edge with start high and busy low
//   letters are always kept; '(' opens, any other non-letter closes when an open is
//   pending; the kept brackets are the earliest-first embedding of the matched ones
//   results leave one beat per strobe cycle on out_char / out_last / out_empty /
//   overflow; the receiver cannot hold them off, each is valid for one cycle only
//   an empty result gives one beat with out_char zero and out_empty, out_last high
//   bytes past MAX_LEN are dropped and every result beat of that string has overflow set
// timing
//   the front queues four beats, so busy rises only while the back replays
//   loading takes one byte per cycle; the replay first primes the store read, then
//   reads each stored byte through the registered read port before advancing,
//   waits while the pattern pointer scans ahead on its own read port, and ends
//   with a closing step that emits the final beat; results trail the walk by
//   one kept byte so the final one can carry out_last
// reset
//   rst is synchronous; it empties the queue, the stack and the match flags;
//   the byte store needs no clearing since only written entries are read
module bracket_balance_filter #(
  parameter int MAX_LEN = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [7:0] in_char,
  input  logic       in_last,
  output logic       strobe,
  output logic [7:0] out_char,
  output logic       out_last,
  output logic       out_empty,
  output logic       overflow
);

  // queue between the front and the back
  logic             q_valid;
  logic             q_pop;
  bbf_pkg::item_t   q_item;
  bbf_pkg::status_t status;

  bbf_front u_front (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .in_char (in_char),
    .in_last (in_last),
    .busy    (busy),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop)
  );

  bbf_back #(.MAX_LEN(MAX_LEN)) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .status    (status),
    .strobe    (strobe),
    .out_char  (out_char),
    .out_last  (out_last),
    .out_empty (out_empty),
    .overflow  (overflow)
  );

  // the back only pulls beats from a non-empty queue
  a_pop_has_item : assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

  // no beat is pulled while a replay is running
  a_pop_in_load : assert property (@(posedge clk) disable iff (rst)
    status.q_pop |-> !status.replay)
    else $error("queue popped during replay");

  // results only follow a replay cycle
  a_result_from_replay : assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(status.replay))
    else $error("result beat outside replay");

  // the empty beat is a lone final beat with a zero byte
  a_empty_form : assert property (@(posedge clk) disable iff (rst)
    (strobe && out_empty) |-> (out_last && out_char == 8'h00))
    else $error("malformed empty result");

endmodule
